### rtl/mss_pkg.sv
// Package for the max step span tracker: field widths, action codes and defaults.
// Has no dependencies. The interfaces, the top level and the testbench refer to it.
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

    // Field widths of the request and result channels.
    localparam int POS_W    = 63;
    localparam int SPAN_W   = 64;
    localparam int STEP_W   = 7;
    localparam int COUNT_W  = 63;
    localparam int PERIOD_W = 63;

    // Default number of slot steps tracked.
    localparam int MAX_STEP_DEF = 40;

    // Period after reset.
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 63'd1;

    // Codes of the action field.
    localparam logic ACT_SLOT   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

endpackage

`default_nettype wire

### rtl/mss_if.sv
// Valid/ready channel interfaces of the max step span tracker: input, result and config.
// Depends on mss_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one request carries an action and a slot position.
interface mss_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [mss_pkg::POS_W-1:0]   position;

    modport source (output valid, output action, output position, input ready);
    modport sink   (input valid, input action, input position, output ready);
endinterface

// Result channel: one request carries one row of the report.
interface mss_out_if;
    logic                        valid;
    logic                        ready;
    logic [mss_pkg::STEP_W-1:0]  step;
    logic [mss_pkg::SPAN_W-1:0]  max_span;
    logic [mss_pkg::SPAN_W-1:0]  span_start;
    logic [mss_pkg::COUNT_W-1:0] slot_count;
    logic                        last_row;

    modport source (output valid, output step, output max_span, output span_start,
                    output slot_count, output last_row, input ready);
    modport sink   (input valid, input step, input max_span, input span_start,
                    input slot_count, input last_row, output ready);
endinterface

// Configuration channel: one request writes the period register.
interface mss_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mss_pkg::PERIOD_W-1:0] period;

    modport source (output valid, output period, input ready);
    modport sink   (input valid, input period, output ready);
endinterface

`default_nettype wire

### rtl/mss_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 41
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/max_step_span_tracker.sv
// Top level of the max step span tracker: sequencer, shared subtract-and-compare unit, RAMs.
// Depends on mss_pkg, the channel interfaces in mss_if and the generic RAM mss_ram.
//
// The block takes strictly increasing slot positions and, for each step count m from 1 to
// MAX_STEP, keeps the largest span between positions m slots apart and where it starts.
// A position that is not above the previous one is dropped. An accepted position is written
// to the ring in the push state and then compared in the compare state, one step at a time,
// up to MAX_STEP steps once the ring of recent positions is full, since the single
// subtract-and-compare unit visits the steps one at a time through the one read port of the
// ring RAM. A finish request replays up to MAX_STEP + 1 stored first positions plus the
// period, each read and checked and followed by a full push when it is kept, and then
// delivers MAX_STEP rows, each read, loaded and held until the result side takes it.
// After the last row all run state is cleared and the period register is kept.
// Input is taken only while the sequencer is idle. The span table needs no clearing pass:
// one valid flag per step stands for its zero value.
`timescale 1ns / 1ps
`default_nettype none

module max_step_span_tracker #(
    parameter int MAX_STEP = mss_pkg::MAX_STEP_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mss_in_if.sink     i_in,
    mss_out_if.source  o_out,
    mss_cfg_if.sink    i_cfg
);

    localparam int D  = MAX_STEP + 1;
    localparam int RW = $clog2(D);
    localparam int BW = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
    localparam int FW = $clog2(D + 1);
    localparam int MW = $clog2(MAX_STEP + 1);
    localparam int SW = mss_pkg::SPAN_W;
    localparam int PW = mss_pkg::POS_W;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PUSH     = 8'b0000_0010,
        S_CMP      = 8'b0000_0100,
        S_WRAP_RD  = 8'b0000_1000,
        S_WRAP_CHK = 8'b0001_0000,
        S_RPT_RD   = 8'b0010_0000,
        S_RPT_LD   = 8'b0100_0000,
        S_RPT_WAIT = 8'b1000_0000
    } t_state;

    t_state                          r_state, n_state;
    logic [mss_pkg::PERIOD_W-1:0]    r_period;
    logic [SW-1:0]                   r_last, n_last;
    logic [SW-1:0]                   r_pos, n_pos;
    logic [RW-1:0]                   r_head, n_head;
    logic [FW-1:0]                   r_fill, n_fill;
    logic [FW-1:0]                   r_ffill, n_ffill;
    logic [mss_pkg::COUNT_W-1:0]     r_count, n_count;
    logic [MAX_STEP-1:0]             r_bvalid, n_bvalid;
    logic [RW-1:0]                   r_rd, n_rd;
    logic [MW-1:0]                   r_m, n_m;
    logic [MW-1:0]                   r_ncmp, n_ncmp;
    logic [FW-1:0]                   r_k, n_k;
    logic                            r_wrap, n_wrap;
    logic                            r_out_valid, n_out_valid;
    logic [mss_pkg::STEP_W-1:0]      r_out_step, n_out_step;
    logic [SW-1:0]                   r_out_span, n_out_span;
    logic [SW-1:0]                   r_out_start, n_out_start;
    logic                            r_out_last, n_out_last;

    // RAM port signals.
    logic                ring_we;
    logic [RW-1:0]       ring_raddr;
    logic [SW-1:0]       ring_q;
    logic                first_we;
    logic [PW-1:0]       first_q;
    logic                best_we;
    logic [BW-1:0]       best_waddr;
    logic [2*SW-1:0]     best_wdata;
    logic [BW-1:0]       best_raddr;
    logic [2*SW-1:0]     best_q;

    // Handshakes and datapath terms.
    logic                in_acc;
    logic                out_acc;
    logic [SW-1:0]       in_pos;
    logic                in_inc;
    logic [SW-1:0]       wrap_pos;
    logic                wrap_inc;
    logic [BW-1:0]       m_idx;
    logic [SW-1:0]       cmp_best;
    logic [SW-1:0]       cmp_diff;
    logic                cmp_win;
    logic [RW-1:0]       head_dec;
    logic [RW-1:0]       rd_dec;
    logic [BW-1:0]       k_idx;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_acc     = r_out_valid && o_out.ready;

    // Increasing checks for a fresh position and for a replayed first position.
    assign in_pos   = {1'b0, i_in.position};
    assign in_inc   = (r_fill == '0) || (in_pos > r_last);
    assign wrap_pos = {1'b0, first_q} + {1'b0, r_period};
    assign wrap_inc = (r_fill == '0) || (wrap_pos > r_last);

    // The shared unit: span to the position m slots back, against the best kept so far.
    assign m_idx    = BW'(r_m - MW'(1));
    assign cmp_best = r_bvalid[m_idx] ? best_q[SW-1:0] : '0;
    assign cmp_diff = r_pos - ring_q;
    assign cmp_win  = cmp_diff > cmp_best;

    // Ring pointers step backwards modulo the ring depth.
    assign head_dec = (r_head == '0) ? RW'(D - 1) : r_head - RW'(1);
    assign rd_dec   = (r_rd == '0) ? RW'(D - 1) : r_rd - RW'(1);
    assign k_idx    = BW'(r_k);

    // Sequencer and next-state logic.
    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_pos       = r_pos;
        n_head      = r_head;
        n_fill      = r_fill;
        n_ffill     = r_ffill;
        n_count     = r_count;
        n_bvalid    = r_bvalid;
        n_rd        = r_rd;
        n_m         = r_m;
        n_ncmp      = r_ncmp;
        n_k         = r_k;
        n_wrap      = r_wrap;
        n_out_valid = r_out_valid;
        n_out_step  = r_out_step;
        n_out_span  = r_out_span;
        n_out_start = r_out_start;
        n_out_last  = r_out_last;
        ring_we     = 1'b0;
        ring_raddr  = r_rd;
        first_we    = 1'b0;
        best_we     = 1'b0;
        best_waddr  = m_idx;
        best_wdata  = {ring_q, cmp_diff};
        best_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.action == mss_pkg::ACT_FINISH) begin
                        n_wrap  = 1'b1;
                        n_k     = '0;
                        n_state = S_WRAP_RD;
                    end else if (in_inc) begin
                        if (r_ffill < FW'(D)) begin
                            first_we = 1'b1;
                            n_ffill  = r_ffill + FW'(1);
                        end
                        n_count = r_count + mss_pkg::COUNT_W'(1);
                        n_pos   = in_pos;
                        n_wrap  = 1'b0;
                        n_state = S_PUSH;
                    end
                end
            end

            // Write the ring and start the read for one step back.
            S_PUSH: begin
                ring_we    = 1'b1;
                n_head     = (r_head == RW'(D - 1)) ? '0 : r_head + RW'(1);
                n_fill     = (r_fill == FW'(D)) ? r_fill : r_fill + FW'(1);
                n_last     = r_pos;
                n_ncmp     = (r_fill >= FW'(MAX_STEP)) ? MW'(MAX_STEP) : MW'(r_fill);
                ring_raddr = head_dec;
                n_rd       = head_dec;
                best_raddr = '0;
                n_m        = MW'(1);
                if (r_fill == '0) begin
                    n_state = r_wrap ? S_WRAP_RD : S_IDLE;
                end else begin
                    n_state = S_CMP;
                end
            end

            // Compare one step, and read the next one in the same cycle.
            S_CMP: begin
                if (cmp_win) begin
                    best_we         = 1'b1;
                    n_bvalid[m_idx] = 1'b1;
                end
                if (r_m == r_ncmp) begin
                    n_state = r_wrap ? S_WRAP_RD : S_IDLE;
                end else begin
                    n_m        = r_m + MW'(1);
                    ring_raddr = rd_dec;
                    n_rd       = rd_dec;
                    best_raddr = BW'(r_m);
                end
            end

            // Replay the stored first positions plus the period.
            S_WRAP_RD: begin
                if (r_k == r_ffill) begin
                    n_k     = '0;
                    n_wrap  = 1'b0;
                    n_state = S_RPT_RD;
                end else begin
                    n_state = S_WRAP_CHK;
                end
            end

            S_WRAP_CHK: begin
                n_k = r_k + FW'(1);
                if (wrap_inc) begin
                    n_pos   = wrap_pos;
                    n_state = S_PUSH;
                end else begin
                    n_state = S_WRAP_RD;
                end
            end

            // Report one row per step.
            S_RPT_RD: begin
                best_raddr = k_idx;
                n_state    = S_RPT_LD;
            end

            S_RPT_LD: begin
                n_out_valid = 1'b1;
                n_out_step  = mss_pkg::STEP_W'(r_k) + mss_pkg::STEP_W'(1);
                n_out_span  = r_bvalid[k_idx] ? best_q[SW-1:0] : '0;
                n_out_start = r_bvalid[k_idx] ? best_q[2*SW-1:SW] : '0;
                n_out_last  = (r_k == FW'(MAX_STEP - 1));
                n_state     = S_RPT_WAIT;
            end

            S_RPT_WAIT: begin
                if (out_acc) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_head   = '0;
                        n_fill   = '0;
                        n_ffill  = '0;
                        n_count  = '0;
                        n_bvalid = '0;
                        n_k      = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_k     = r_k + FW'(1);
                        n_state = S_RPT_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= mss_pkg::PERIOD_RST;
            r_head      <= '0;
            r_fill      <= '0;
            r_ffill     <= '0;
            r_count     <= '0;
            r_bvalid    <= '0;
            r_rd        <= '0;
            r_m         <= '0;
            r_ncmp      <= '0;
            r_k         <= '0;
            r_wrap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_ffill     <= n_ffill;
            r_count     <= n_count;
            r_bvalid    <= n_bvalid;
            r_rd        <= n_rd;
            r_m         <= n_m;
            r_ncmp      <= n_ncmp;
            r_k         <= n_k;
            r_wrap      <= n_wrap;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_period <= i_cfg.period;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_pos       <= n_pos;
        r_out_step  <= n_out_step;
        r_out_span  <= n_out_span;
        r_out_start <= n_out_start;
        r_out_last  <= n_out_last;
    end

    // Ring of the most recent positions.
    mss_ram #(
        .WIDTH (SW),
        .DEPTH (D)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_head),
        .i_wdata (r_pos),
        .i_raddr (ring_raddr),
        .o_rdata (ring_q)
    );

    // Store of the first positions of the run.
    mss_ram #(
        .WIDTH (PW),
        .DEPTH (D)
    ) u_first (
        .i_clk   (i_clk),
        .i_we    (first_we),
        .i_waddr (r_ffill[RW-1:0]),
        .i_wdata (i_in.position),
        .i_raddr (r_k[RW-1:0]),
        .o_rdata (first_q)
    );

    // Best span and its start per step, start in the upper half.
    mss_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_STEP)
    ) u_best (
        .i_clk   (i_clk),
        .i_we    (best_we),
        .i_waddr (best_waddr),
        .i_wdata (best_wdata),
        .i_raddr (best_raddr),
        .o_rdata (best_q)
    );

    // Result channel.
    assign o_out.valid      = r_out_valid;
    assign o_out.step       = r_out_step;
    assign o_out.max_span   = r_out_span;
    assign o_out.span_start = r_out_start;
    assign o_out.slot_count = r_count;
    assign o_out.last_row   = r_out_last;

    // A result is only on offer while the sequencer waits for it to be taken.
    a_out_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_RPT_WAIT))
        else $error("result valid outside the report wait state");

    // The ring never holds more than its depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FW'(D)) && (r_ffill <= FW'(D)))
        else $error("ring or first store fill beyond depth");

    // The step under comparison stays within the steps that have a pair.
    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((r_m != '0) && (r_m <= r_ncmp)))
        else $error("compared step out of range");

    // Taking the last row leaves a cleared run ready for new input.
    a_clear_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_out_last) |=>
            ((r_fill == '0) && (r_count == '0) && (r_bvalid == '0) && i_in.ready))
        else $error("run state not cleared after the last row");

endmodule

`default_nettype wire

### tb/tb_max_step_span_tracker.sv
// Self-checking testbench for the max step span tracker: directed cycle reports, then random
// runs of rising slot positions with random idling, back-pressure and period changes.
// Depends on mss_pkg, the channel interfaces in mss_if and the max_step_span_tracker RTL.
`timescale 1ns / 1ps

module tb_max_step_span_tracker;

    localparam int          MS         = mss_pkg::MAX_STEP_DEF;
    localparam int          RD         = MS + 1;
    localparam int          SETTLE     = 2 * (MS + 2);
    localparam int          CYCLE_CAP  = 500000;
    localparam logic [63:0] POS_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

    // One row of the span report as the result channel carries it.
    typedef struct {
        logic [mss_pkg::STEP_W-1:0]  step;
        logic [mss_pkg::SPAN_W-1:0]  max_span;
        logic [mss_pkg::SPAN_W-1:0]  span_start;
        logic [mss_pkg::COUNT_W-1:0] slot_count;
        logic                        last_row;
    } t_span_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mss_in_if  in_if ();
    mss_out_if out_if ();
    mss_cfg_if cfg_if ();

    max_step_span_tracker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Free-running 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Span tracking state kept alongside the block.
    logic [mss_pkg::PERIOD_W-1:0] period_q;
    logic [63:0]                  ring_pos   [RD];
    logic [63:0]                  first_pos  [RD];
    logic [63:0]                  top_span   [MS];
    logic [63:0]                  top_start  [MS];
    int unsigned                  ring_at, ring_cnt, first_cnt;
    logic [mss_pkg::COUNT_W-1:0]  slots_taken;

    t_span_row   rows_due [$];
    int unsigned kept_cnt, dropped_cnt, report_cnt, rows_seen, cfg_writes, mismatches;
    int unsigned cycles;
    bit          idle_on;
    int          hold_ask, hold_left, stall_left;

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [mss_pkg::POS_W-1:0] rnd63();
        logic [63:0] r;
        r = rnd64();
        return r[mss_pkg::POS_W-1:0];
    endfunction

    function automatic void clear_run();
        foreach (ring_pos[i]) ring_pos[i] = '0;
        foreach (first_pos[i]) first_pos[i] = '0;
        foreach (top_span[i]) top_span[i] = '0;
        foreach (top_start[i]) top_start[i] = '0;
        ring_at     = 0;
        ring_cnt    = 0;
        first_cnt   = 0;
        slots_taken = '0;
    endfunction

    // A position counts only when above the newest one held, or when the ring is empty.
    function automatic bit above_newest(input logic [63:0] p);
        if (ring_cnt == 0) return 1'b1;
        return p > ring_pos[(ring_at + MS) % RD];
    endfunction

    // Enter a position into the ring and update the widest span for every step count.
    function automatic void push_pos(input logic [63:0] p);
        logic [63:0] older;
        logic [63:0] gap;
        ring_pos[ring_at] = p;
        ring_at = (ring_at + 1) % RD;
        if (ring_cnt < RD) ring_cnt++;
        for (int m = 1; m <= MS && m < ring_cnt; m++) begin
            older = ring_pos[(ring_at + MS - m) % RD];
            gap   = p - older;
            // Only a strictly wider span replaces the kept one, so the first found wins.
            if (gap > top_span[m-1]) begin
                top_span[m-1]  = gap;
                top_start[m-1] = older;
            end
        end
    endfunction

    function automatic void take_position(input logic [63:0] p);
        if (!above_newest(p)) begin
            dropped_cnt++;
            return;
        end
        if (first_cnt < RD) begin
            first_pos[first_cnt] = p;
            first_cnt++;
        end
        slots_taken = slots_taken + 1'b1;
        kept_cnt++;
        push_pos(p);
    endfunction

    // Replay the first positions one period on to close the cycle, then queue the report.
    function automatic void close_cycle();
        logic [63:0] wrapped;
        t_span_row   row;
        for (int k = 0; k < first_cnt; k++) begin
            wrapped = first_pos[k] + {1'b0, period_q};
            if (above_newest(wrapped)) push_pos(wrapped);
        end
        for (int m = 0; m < MS; m++) begin
            row.step       = mss_pkg::STEP_W'(m + 1);
            row.max_span   = top_span[m];
            row.span_start = top_start[m];
            row.slot_count = slots_taken;
            row.last_row   = (m == MS - 1);
            rows_due.push_back(row);
        end
        report_cnt++;
        clear_run();
    endfunction

    // Receiver: random stall bursts, plus a long hold-off when one is asked for.
    always @(posedge i_clk) begin
        if (hold_ask > 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 10);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Compare every accepted report row with the oldest one still due.
    always @(posedge i_clk) begin : row_check
        t_span_row want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected row: step %0d span %h start %h count %0d last %0b",
                             out_if.step, out_if.max_span, out_if.span_start,
                             out_if.slot_count, out_if.last_row);
            end else begin
                want = rows_due.pop_front();
                rows_seen++;
                if (want.step !== out_if.step || want.max_span !== out_if.max_span ||
                    want.span_start !== out_if.span_start ||
                    want.slot_count !== out_if.slot_count ||
                    want.last_row !== out_if.last_row) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"Row mismatch, expected: step %0d span %h start %h",
                                  " count %0d last %0b"},
                                 want.step, want.max_span, want.span_start,
                                 want.slot_count, want.last_row);
                        $display({"               actual: step %0d span %h start %h",
                                  " count %0d last %0b"},
                                 out_if.step, out_if.max_span, out_if.span_start,
                                 out_if.slot_count, out_if.last_row);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Timeout after %0d cycles with %0d rows still due",
                     cycles, rows_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one request and wait until it is taken; valid stays high for a following request.
    task automatic send_item(input logic act, input logic [mss_pkg::POS_W-1:0] pos);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.action   <= act;
        in_if.position <= pos;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        if (act == mss_pkg::ACT_FINISH) close_cycle();
        else take_position({1'b0, pos});
    endtask

    task automatic stop_sending();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (rows_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic finish_run();
        send_item(mss_pkg::ACT_FINISH, rnd63());
        stop_sending();
        wait_drained();
    endtask

    // The period is changed only with the block idle: report drained and a full push allowed for.
    task automatic write_period(input logic [mss_pkg::PERIOD_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        cfg_if.valid  <= 1'b1;
        cfg_if.period <= value;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        period_q = value;
        cfg_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [mss_pkg::PERIOD_W-1:0] pick_period();
        logic [mss_pkg::POS_W-1:0] r;
        r = rnd63();
        case ($urandom_range(0, 5))
            0:       return mss_pkg::PERIOD_W'(1);
            1:       return POS_MAX[mss_pkg::PERIOD_W-1:0];
            2:       return mss_pkg::PERIOD_W'($urandom_range(2, 60));
            3:       return mss_pkg::PERIOD_W'($urandom_range(61, 100000));
            4:       return r >> $urandom_range(1, 40);
            default: return r;
        endcase
    endfunction

    // A position at or below the newest kept one, which the block must drop.
    function automatic logic [mss_pkg::POS_W-1:0] stale_pos(input logic [63:0] newest);
        logic [63:0] v;
        v = newest - rnd64() % (newest + 64'd1);
        return v[mss_pkg::POS_W-1:0];
    endfunction

    // One run of rising positions up to hi, with stale ones mixed in, closed by a finish.
    task automatic send_run(input int unsigned len, input logic [63:0] hi, input bit tie_bias);
        logic [63:0] cur;
        logic [63:0] nxt;
        logic [63:0] room;
        logic [63:0] per;
        bit          have;
        have = 1'b0;
        cur  = '0;
        for (int unsigned i = 0; i < len; i++) begin
            if (have && $urandom_range(0, 7) == 0)
                send_item(mss_pkg::ACT_SLOT, stale_pos(cur));
            if (!have) begin
                nxt = rnd64() % ((hi >> $urandom_range(0, 62)) + 64'd1);
            end else begin
                room = hi - cur;
                if (room == 0) break;
                per = room / (len - i);
                if (per == 0) per = 1;
                // Narrow steps make equal spans, which exercise the tie rule.
                if (tie_bias && per > 4) per = 4;
                nxt = cur + 64'd1 + rnd64() % per;
            end
            send_item(mss_pkg::ACT_SLOT, nxt[mss_pkg::POS_W-1:0]);
            cur  = nxt;
            have = 1'b1;
        end
        finish_run();
    endtask

    // A finish with no positions reports all zero rows.
    task automatic test_empty_finish();
        send_item(mss_pkg::ACT_FINISH, rnd63());
        stop_sending();
        wait_drained();
    endtask

    // Small cycle with equal spans and repeated or falling positions that are dropped.
    task automatic test_short_cycle();
        write_period(mss_pkg::PERIOD_W'(10));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(0));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(2));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(4));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(4));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(1));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(5));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(9));
        finish_run();
    endtask

    // One position with a period of one: only the wrap gives a span.
    task automatic test_single_slot();
        write_period(mss_pkg::PERIOD_W'(1));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(0));
        finish_run();
    endtask

    // Largest period and positions; position 0 wraps onto the top position, so its wrap is skipped.
    task automatic test_position_extremes();
        write_period(POS_MAX[mss_pkg::PERIOD_W-1:0]);
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(0));
        send_item(mss_pkg::ACT_SLOT, POS_MAX[mss_pkg::POS_W-1:0] - 1'b1);
        send_item(mss_pkg::ACT_SLOT, POS_MAX[mss_pkg::POS_W-1:0]);
        finish_run();
    endtask

    // With a zero period no replayed position rises, so the wrap adds nothing.
    task automatic test_zero_period();
        write_period('0);
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(3));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(8));
        finish_run();
    endtask

    // Receiver holds off while a second run is offered, so the block stalls its input.
    task automatic test_result_backpressure();
        write_period(mss_pkg::PERIOD_W'(20));
        idle_on  = 1'b0;
        hold_ask = 600;
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(0));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(4));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(6));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(13));
        send_item(mss_pkg::ACT_FINISH, rnd63());
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(2));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(5));
        send_item(mss_pkg::ACT_SLOT, mss_pkg::POS_W'(19));
        finish_run();
        idle_on = 1'b1;
    endtask

    // Random runs until enough positions and finishes have been taken.
    task automatic test_random_runs(input int unsigned target, input bit quiet);
        int unsigned base;
        int unsigned len;
        bit          first_pass;
        logic [63:0] hi;
        base       = kept_cnt + report_cnt;
        first_pass = 1'b1;
        while (kept_cnt + report_cnt - base < target) begin
            if (first_pass && !quiet) write_period(rnd63() | (mss_pkg::POS_W'(1) << 40));
            else if ($urandom_range(0, 1) == 1) write_period(pick_period());
            idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (first_pass && !quiet) len = 45;
            else if ($urandom_range(0, 4) == 0) len = $urandom_range(38, 48);
            else len = $urandom_range(0, 10);
            // Now and then positions run past the period, so some wrap entries are skipped.
            if (period_q == 0 || $urandom_range(0, 9) == 0) hi = POS_MAX;
            else hi = {1'b0, period_q} - 64'd1;
            send_run(len, hi, $urandom_range(0, 3) == 0);
            first_pass = 1'b0;
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.action   = mss_pkg::ACT_SLOT;
        in_if.position = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.period  = '0;
        out_if.ready   = 1'b0;
        idle_on        = 1'b1;
        period_q       = mss_pkg::PERIOD_RST;
        clear_run();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_finish();
        test_short_cycle();
        test_single_slot();
        test_position_extremes();
        test_zero_period();
        test_result_backpressure();
        test_random_runs(55, 1'b0);
        test_random_runs(15, 1'b1);

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        $display("Run covered %0d cycle reports, %0d rows checked, %0d period writes.",
                 report_cnt, rows_seen, cfg_writes);
        $display("Positions kept %0d, dropped %0d; mismatches %0d.",
                 kept_cnt, dropped_cnt, mismatches);
        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
